// ===== rtl/core/lprd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the length-prefixed record deframer.
// No dependencies; used by the front, queue, back and top level.
package lprd_pkg;

    localparam logic [7:0] GROUP_MASK = 8'h7F;
    localparam logic [7:0] STOP_FLAG  = 8'h80;
    localparam int         GROUP_BITS = 7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IW    = $clog2(QUEUE_DEPTH);

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_CLOSE  = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_STOPPED = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_CLEAN    = 3'd0,
        ST_LIMIT    = 3'd1,
        ST_HDR_CUT  = 3'd2,
        ST_PAY_CUT  = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    // One queue entry: the results caused by one input byte.
    typedef struct packed {
        logic        has_desc;
        logic [31:0] desc_offset;
        logic [31:0] desc_length;
        logic [15:0] desc_index;
        logic        has_close;
        logic [15:0] close_count;
        t_status     close_status;
    } t_entry;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

endpackage

// ===== rtl/core/length_prefixed_record_deframer.sv =====
`timescale 1ns / 1ps
// Length-prefixed record deframer, top level. Depends on lprd_pkg, lprd_front,
// lprd_queue and lprd_back.
//
// Input side is a queue write port: present one buffer byte on i_data_byte
// with i_end_of_buffer on the buffer's last byte and raise push; the byte is
// taken at an edge where full is low. Result side is a queue read port: while
// empty is low the oldest result is on the o_ ports, and pop takes it.
// Each record gives a descriptor (kind 0) when its last payload byte arrives;
// the buffer's last byte also gives a closing result (kind 1) with the record
// count and status. o_last marks the last result caused by one byte.
// Throughput: one byte per cycle while full is low; a byte that yields two
// results holds the output register for both in turn. A result passes through
// the queue and the output register. A four-entry queue separates parser and
// output; when pop is held low it fills and full rises, holding the input.
// Reset (synchronous, active low) empties the queue, clears the parser and
// sets max_records to 65535. i_cfg_wr_en writes max_records; write it only
// while no item is in flight.
module length_prefixed_record_deframer import lprd_pkg::*; #(
    parameter int LEN_BITS    = 32,
    parameter int OFFSET_BITS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [31:0] o_record_offset,
    output logic [31:0] o_record_length,
    output logic [15:0] o_record_count,
    output logic [2:0]  o_status,
    output logic        o_last
);

    t_q_status w_q_status;
    t_entry    w_entry;
    t_entry    w_head;
    logic      w_accept;
    logic      w_push;
    logic      w_take;

    assign full     = w_q_status.full;
    assign w_accept = push && !w_q_status.full;

    lprd_front #(
        .LEN_BITS    (LEN_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_accept        (w_accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_push          (w_push),
        .o_entry         (w_entry)
    );

    lprd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (w_push),
        .i_entry   (w_entry),
        .i_pop_en  (w_take),
        .o_status  (w_q_status),
        .o_head    (w_head)
    );

    lprd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (w_q_status),
        .i_head          (w_head),
        .o_take          (w_take),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_kind          (o_kind),
        .o_record_offset (o_record_offset),
        .o_record_length (o_record_length),
        .o_record_count  (o_record_count),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_close_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_CLOSE) |-> o_last)
        else $error("closing result not marked last");

    a_desc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_RECORD) |-> (o_status == ST_CLEAN))
        else $error("descriptor carries a status");

    a_close_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last) |=> (!empty && o_kind == KIND_CLOSE))
        else $error("closing result does not follow its descriptor");

endmodule

// ===== rtl/core/lprd_front.sv =====
`timescale 1ns / 1ps
// Front of the deframer: parses prefix bytes, counts payload bytes and builds
// one queue entry per byte that produces results. Depends on lprd_pkg.
module lprd_front import lprd_pkg::*; #(
    parameter int LEN_BITS    = 32,
    parameter int OFFSET_BITS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    output logic        o_push,
    output t_entry      o_entry
);

    localparam int GROUPS = (LEN_BITS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int GW     = $clog2(GROUPS + 1);
    localparam int SW     = $clog2(GROUPS * GROUP_BITS + 1);
    localparam int XW     = LEN_BITS + GROUP_BITS;
    localparam logic [31:0] CMAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    logic [15:0]            r_max_records;
    t_phase                 r_phase, n_phase, s_phase;
    t_status                r_stop, n_stop, s_stop;
    logic [LEN_BITS-1:0]    r_accum, n_accum, s_accum;
    logic [GW-1:0]          r_group, n_group, s_group;
    logic [LEN_BITS-1:0]    r_left, n_left, s_left;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [OFFSET_BITS-1:0] r_pstart, n_pstart, s_pstart;
    logic [COUNT_BITS-1:0]  r_count, n_count, s_count;

    logic [31:0]            w_limit;
    logic                   w_at_limit;
    logic [SW-1:0]          w_shamt;
    logic [XW-1:0]          w_shifted;
    logic                   w_ovf;
    logic [LEN_BITS-1:0]    w_accum_new;
    logic [LEN_BITS-1:0]    w_left_dec;
    logic [OFFSET_BITS-1:0] w_next;
    logic                   w_done;
    logic [31:0]            w_desc_off;
    logic [31:0]            w_desc_len;
    t_status                w_close_status;

    assign w_limit    = (32'(r_max_records) < CMAX) ? 32'(r_max_records) : CMAX;
    assign w_at_limit = 32'(r_count) >= w_limit;
    assign w_shamt    = SW'(r_group) * SW'(GROUP_BITS);
    assign w_shifted  = XW'(i_data_byte & GROUP_MASK) << w_shamt;
    assign w_ovf      = (32'(r_group) >= 32'(GROUPS)) || (|w_shifted[XW-1:LEN_BITS]);
    assign w_accum_new = r_accum | w_shifted[LEN_BITS-1:0];
    assign w_left_dec = r_left - LEN_BITS'(1);
    assign w_next     = r_offset + OFFSET_BITS'(1);

    // Next state: step of the parser, before the end-of-buffer clear.
    always_comb begin
        s_phase  = r_phase;
        s_stop   = r_stop;
        s_accum  = r_accum;
        s_group  = r_group;
        s_left   = r_left;
        s_pstart = r_pstart;
        s_count  = r_count;
        w_done   = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                if (r_group == '0 && w_at_limit) begin
                    s_phase = PH_STOPPED;
                    s_stop  = ST_LIMIT;
                end else if (w_ovf) begin
                    s_phase = PH_STOPPED;
                    s_stop  = ST_OVERFLOW;
                end else if ((i_data_byte & STOP_FLAG) == 8'h00) begin
                    s_accum = w_accum_new;
                    s_group = r_group + GW'(1);
                end else begin
                    s_group = '0;
                    if (w_accum_new == '0) begin
                        w_done = 1'b1;
                    end else begin
                        s_accum  = w_accum_new;
                        s_phase  = PH_PAYLOAD;
                        s_left   = w_accum_new;
                        s_pstart = w_next;
                    end
                end
            end
            PH_PAYLOAD: begin
                s_left = w_left_dec;
                if (w_left_dec == '0) begin
                    w_done = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (w_done) begin
            s_count = r_count + COUNT_BITS'(1);
            s_accum = '0;
            s_group = '0;
            s_left  = '0;
            if (32'(s_count) >= w_limit) begin
                s_phase = PH_STOPPED;
                s_stop  = ST_LIMIT;
            end else begin
                s_phase = PH_HEADER;
            end
        end
    end

    // Commit on an accepted byte; the buffer's last byte returns to reset.
    always_comb begin
        n_phase  = r_phase;
        n_stop   = r_stop;
        n_accum  = r_accum;
        n_group  = r_group;
        n_left   = r_left;
        n_offset = r_offset;
        n_pstart = r_pstart;
        n_count  = r_count;
        if (i_accept) begin
            if (i_end_of_buffer) begin
                n_phase  = PH_HEADER;
                n_stop   = ST_CLEAN;
                n_accum  = '0;
                n_group  = '0;
                n_left   = '0;
                n_offset = '0;
                n_pstart = '0;
                n_count  = '0;
            end else begin
                n_phase  = s_phase;
                n_stop   = s_stop;
                n_accum  = s_accum;
                n_group  = s_group;
                n_left   = s_left;
                n_offset = w_next;
                n_pstart = s_pstart;
                n_count  = s_count;
            end
        end
    end

    // Outputs: the queue entry for this byte.
    always_comb begin
        if (r_phase == PH_HEADER) begin
            w_desc_off = 32'(w_next);
            w_desc_len = 32'd0;
        end else begin
            w_desc_off = 32'(r_pstart);
            w_desc_len = 32'(r_accum);
        end
        if (s_phase == PH_STOPPED) begin
            w_close_status = s_stop;
        end else if (s_phase == PH_PAYLOAD) begin
            w_close_status = ST_PAY_CUT;
        end else if (s_group != '0) begin
            w_close_status = ST_HDR_CUT;
        end else begin
            w_close_status = ST_CLEAN;
        end
        o_entry.has_desc     = w_done;
        o_entry.desc_offset  = w_desc_off;
        o_entry.desc_length  = w_desc_len;
        o_entry.desc_index   = 16'(r_count);
        o_entry.has_close    = i_end_of_buffer;
        o_entry.close_count  = 16'(s_count);
        o_entry.close_status = w_close_status;
        o_push = i_accept && (w_done || i_end_of_buffer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_records <= 16'hFFFF;
            r_phase       <= PH_HEADER;
            r_stop        <= ST_CLEAN;
            r_accum       <= '0;
            r_group       <= '0;
            r_left        <= '0;
            r_offset      <= '0;
            r_pstart      <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_records <= i_cfg_wr_data;
            end
            r_phase  <= n_phase;
            r_stop   <= n_stop;
            r_accum  <= n_accum;
            r_group  <= n_group;
            r_left   <= n_left;
            r_offset <= n_offset;
            r_pstart <= n_pstart;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/core/lprd_queue.sv =====
`timescale 1ns / 1ps
// Short entry queue between the deframer front and back.
// Depends on lprd_pkg for the entry type and depth.
module lprd_queue import lprd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push_en,
    input  t_entry    i_entry,
    input  logic      i_pop_en,
    output t_q_status o_status,
    output t_entry    o_head
);

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_IW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_IW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_IW:0]     r_fill, n_fill;
    logic                  w_push;
    logic                  w_pop;

    assign o_status.full      = r_fill == (QUEUE_IW + 1)'(QUEUE_DEPTH);
    assign o_status.not_empty = r_fill != '0;
    assign o_head             = r_mem[r_rd_ptr];

    assign w_push = i_push_en && !o_status.full;
    assign w_pop  = i_pop_en && o_status.not_empty;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + QUEUE_IW'(1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + QUEUE_IW'(1) : r_rd_ptr;
        n_fill   = r_fill + (QUEUE_IW + 1)'(w_push) - (QUEUE_IW + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

// ===== rtl/core/lprd_back.sv =====
`timescale 1ns / 1ps
// Back of the deframer: output register that splits one queue entry into
// a descriptor and/or a closing result. Depends on lprd_pkg.
module lprd_back import lprd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_status   i_q_status,
    input  t_entry      i_head,
    output logic        o_take,
    input  logic        i_pop,
    output logic        o_empty,
    output logic        o_kind,
    output logic [31:0] o_record_offset,
    output logic [31:0] o_record_length,
    output logic [15:0] o_record_count,
    output logic [2:0]  o_status,
    output logic        o_last
);

    logic   r_valid;
    logic   r_on_close;
    t_entry r_entry;
    logic   w_advance;
    logic   w_to_close;
    logic   w_finish;

    assign w_advance  = i_pop && r_valid;
    assign w_to_close = w_advance && !r_on_close && r_entry.has_close;
    assign w_finish   = !r_valid || (w_advance && !w_to_close);
    assign o_take     = w_finish && i_q_status.not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_on_close <= 1'b0;
        end else if (w_to_close) begin
            r_on_close <= 1'b1;
        end else if (w_finish) begin
            r_valid    <= i_q_status.not_empty;
            r_on_close <= !i_head.has_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_entry <= i_head;
        end
    end

    assign o_empty         = !r_valid;
    assign o_kind          = r_on_close ? KIND_CLOSE : KIND_RECORD;
    assign o_record_offset = r_on_close ? 32'd0 : r_entry.desc_offset;
    assign o_record_length = r_on_close ? 32'd0 : r_entry.desc_length;
    assign o_record_count  = r_on_close ? r_entry.close_count : r_entry.desc_index;
    assign o_status        = r_on_close ? r_entry.close_status : ST_CLEAN;
    assign o_last          = r_on_close || !r_entry.has_close;

endmodule
